@@ rtl/lrsr_pkg.sv @@
// Package for the LR shift-reduce parser: codes, field widths and shared types.
// No dependencies.
package lrsr_pkg;
    localparam int unsigned STATE_W = 8;
    localparam int unsigned SYM_W   = 7;
    localparam int unsigned RULE_W  = 8;
    localparam int unsigned LEN_W   = 7;

    // The stack level is carried in LEN_W bits, so the depth is fixed here.
    localparam int unsigned STACK_DEPTH = 64;

    typedef enum logic [1:0] {
        MODE_CELL    = 2'd0,
        MODE_RULE    = 2'd1,
        MODE_TOKEN   = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_ERROR  = 2'd0,
        ACT_SHIFT  = 2'd1,
        ACT_REDUCE = 2'd2,
        ACT_ACCEPT = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        KIND_SHIFT  = 2'd0,
        KIND_REDUCE = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_ERROR  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_ACTION = 3'd1,
        ERR_NO_GOTO   = 3'd2,
        ERR_EOF       = 3'd3,
        ERR_TERMINAL  = 3'd4,
        ERR_OVERFLOW  = 3'd5,
        ERR_UNDERFLOW = 3'd6,
        ERR_TOO_MANY  = 3'd7
    } t_err;

    typedef enum logic [1:0] {
        RUN_GOING    = 2'd0,
        RUN_ACCEPTED = 2'd1,
        RUN_FAILED   = 2'd2
    } t_run;

    // Result record passed from the engine to the output register.
    typedef struct packed {
        t_kind               kind;
        logic [RULE_W-1:0]   rule;
        logic [SYM_W-1:0]    sym;
        logic [STATE_W-1:0]  state;
        t_err                err;
        logic [LEN_W-1:0]    level;
        logic                last;
    } t_result;
endpackage

@@ rtl/lrsr_out_reg.sv @@
// Output holding register with valid/ready for parser results.
// Depends on lrsr_pkg.
module lrsr_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lrsr_pkg::t_result i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_ready,
    output lrsr_pkg::t_result o_data
);
    import lrsr_pkg::*;

    logic    r_valid;
    t_result r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    // Full only while the held result is not being taken this cycle.
    assign o_full  = r_valid && !i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("result pushed over a held result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ready && !i_push |=> r_valid)
        else $error("held result dropped");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && !i_push |=> !r_valid)
        else $error("taken result not cleared");
endmodule

@@ rtl/lr_shift_reduce_parser.sv @@
// Top level of the table-driven LR shift-reduce parser engine.
// Depends on lrsr_pkg and lrsr_out_reg; holds the action, rule and stack memories.
//
//  channel   direction  signals
//  request   in         i_valid / o_ready, i_mode .. i_end_of_input
//  result    out        o_valid / i_ready, o_result_kind .. o_last
//  config    in         i_cfg_valid / o_cfg_ready, i_cfg_data (terminal_count)
//
// A token for a shift, accept or failed lookup passes through accept, action read,
// decide and emit; an end-of-input or bad-terminal error goes from accept to emit.
// Each reduce adds the steps action read, decide, rule read, stack read, goto read, emit.
// The stores need no clearing pass after reset.
// A pending result stalls the engine only when the output register is still full.
module lr_shift_reduce_parser #(
    parameter int unsigned NUM_STATES     = 256,
    parameter int unsigned NUM_SYMBOLS    = 128,
    parameter int unsigned NUM_RULES      = 256,
    parameter int unsigned MAX_REDUCTIONS = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_table_state,
    input  logic [6:0]  i_table_symbol,
    input  logic [1:0]  i_cell_action,
    input  logic [7:0]  i_cell_target,
    input  logic [7:0]  i_rule_number,
    input  logic [6:0]  i_rule_lhs,
    input  logic [6:0]  i_rule_length,
    input  logic [6:0]  i_token_symbol,
    input  logic        i_token_is_nonterminal,
    input  logic        i_end_of_input,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_result_kind,
    output logic [7:0]  o_reduced_rule,
    output logic [6:0]  o_produced_symbol,
    output logic [7:0]  o_new_state,
    output logic [2:0]  o_error_code,
    output logic [6:0]  o_stack_level,
    output logic        o_last
);
    import lrsr_pkg::*;

    localparam int unsigned SA_W  = (NUM_STATES  > 1) ? $clog2(NUM_STATES)  : 1;
    localparam int unsigned CA_W  = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int unsigned RA_W  = (NUM_RULES   > 1) ? $clog2(NUM_RULES)   : 1;
    localparam int unsigned SP_W  = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W = $clog2(MAX_REDUCTIONS + 1);
    localparam int unsigned COL_W = 9;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_ACT    = 7'b0000010,
        ST_DECIDE = 7'b0000100,
        ST_RULE   = 7'b0001000,
        ST_POP    = 7'b0010000,
        ST_GOTO   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } t_state;

    // Memories.
    logic [9:0]         action_mem [NUM_STATES*NUM_SYMBOLS];
    logic [13:0]        rule_mem   [NUM_RULES];
    logic [STATE_W-1:0] stack_mem  [STACK_DEPTH];

    t_state             r_fsm, n_fsm;
    logic [STATE_W-1:0] r_cur;
    logic [LEN_W-1:0]   r_count;
    t_run               r_run;
    logic [7:0]         r_tcount;
    logic [COL_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_nred;
    logic [RULE_W-1:0]  r_rule;
    logic [SYM_W-1:0]   r_lhs;
    logic [LEN_W-1:0]   r_base;
    logic [STATE_W-1:0] r_prev;
    t_result            r_pend;

    logic [9:0]         act_q;
    logic [13:0]        rule_q;
    logic [STATE_W-1:0] stk_q;

    logic               act_rd_en;
    logic [SA_W+CA_W-1:0] act_rd_addr;
    logic               act_rd_ok, r_act_ok;

    logic    out_push, out_full, out_valid;
    t_result out_data, push_data;

    // Combinational helpers.
    logic [COL_W-1:0] tok_col, goto_col;
    logic [1:0]       dec_act;
    logic [7:0]       dec_tgt;
    logic [SYM_W-1:0] rq_lhs;
    logic [LEN_W-1:0] rq_len;
    logic             accept_in;

    assign accept_in = i_valid && o_ready;
    assign dec_act   = act_q[9:8];
    assign dec_tgt   = act_q[7:0];
    assign rq_lhs    = rule_q[13:7];
    assign rq_len    = rule_q[6:0];
    assign tok_col   = {2'b00, i_token_symbol}
                       + (i_token_is_nonterminal ? {1'b0, r_tcount} : {COL_W{1'b0}});
    assign goto_col  = {2'b00, r_lhs} + {1'b0, r_tcount};

    assign o_ready     = (r_fsm == ST_IDLE);
    assign o_cfg_ready = (r_fsm == ST_IDLE);

    // Read address for the action memory: token lookup or goto lookup.
    always_comb begin
        act_rd_en   = 1'b0;
        act_rd_ok   = 1'b0;
        act_rd_addr = '0;
        if (r_fsm == ST_ACT) begin
            act_rd_en   = 1'b1;
            act_rd_ok   = (32'(r_cur) < NUM_STATES) && (32'(r_col) < NUM_SYMBOLS);
            act_rd_addr = (SA_W+CA_W)'(32'(r_cur) * NUM_SYMBOLS + 32'(r_col));
        end else if (r_fsm == ST_GOTO) begin
            act_rd_en   = 1'b1;
            act_rd_ok   = (32'(r_prev) < NUM_STATES) && (32'(goto_col) < NUM_SYMBOLS);
            act_rd_addr = (SA_W+CA_W)'(32'(r_prev) * NUM_SYMBOLS + 32'(goto_col));
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && t_mode'(i_mode) == MODE_CELL
                && 32'(i_table_state) < NUM_STATES && 32'(i_table_symbol) < NUM_SYMBOLS) begin
            action_mem[(SA_W+CA_W)'(32'(i_table_state) * NUM_SYMBOLS
                                    + 32'(i_table_symbol))] <= {i_cell_action, i_cell_target};
        end
        if (act_rd_en) begin
            act_q <= action_mem[act_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && t_mode'(i_mode) == MODE_RULE && 32'(i_rule_number) < NUM_RULES) begin
            rule_mem[RA_W'(i_rule_number)] <= {i_rule_lhs, i_rule_length};
        end
        if (r_fsm == ST_DECIDE) begin
            rule_q <= rule_mem[RA_W'(dec_tgt)];
        end
    end

    // Stack: push of the current state on shift, write of the uncovered state
    // on reduce, read of the uncovered state.
    logic               stk_we;
    logic [SP_W-1:0]    stk_waddr;
    logic [STATE_W-1:0] stk_wdata;
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        if (r_fsm == ST_RULE) begin
            stk_q <= stack_mem[SP_W'(r_count - rq_len)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_IDLE;
            r_cur    <= '0;
            r_count  <= '0;
            r_run    <= RUN_GOING;
            r_tcount <= 8'd1;
            r_act_ok <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (act_rd_en) begin
                r_act_ok <= act_rd_ok;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_tcount <= i_cfg_data;
            end
            if (accept_in && t_mode'(i_mode) == MODE_RESTART) begin
                r_cur   <= '0;
                r_count <= '0;
                r_run   <= RUN_GOING;
            end
            if (out_push) begin
                if (push_data.kind == KIND_ERROR) begin
                    r_run <= RUN_FAILED;
                end else if (push_data.kind == KIND_ACCEPT) begin
                    r_run <= RUN_ACCEPTED;
                end else begin
                    r_cur   <= push_data.state;
                    r_count <= push_data.level;
                end
            end
        end
    end

    // A shift or reduce push commits its state and stack level above; others end the run.
    function automatic t_result mk_err(t_err e, logic [STATE_W-1:0] s, logic [LEN_W-1:0] l);
        t_result r;
        r.kind  = KIND_ERROR;
        r.rule  = '0;
        r.sym   = '0;
        r.state = s;
        r.err   = e;
        r.level = l;
        r.last  = 1'b1;
        return r;
    endfunction

    logic             r_emit_hold;
    t_result          n_pend;
    logic             pend_ld;

    always_comb begin
        n_fsm     = r_fsm;
        out_push  = 1'b0;
        push_data = r_pend;
        n_pend    = r_pend;
        pend_ld   = 1'b0;
        stk_we    = 1'b0;
        stk_waddr = SP_W'(r_count);
        stk_wdata = r_cur;
        case (r_fsm)
            ST_IDLE: begin
                if (accept_in && t_mode'(i_mode) == MODE_TOKEN && r_run == RUN_GOING) begin
                    if (i_end_of_input) begin
                        n_pend = mk_err(ERR_EOF, r_cur, r_count); pend_ld = 1'b1;
                        n_fsm  = ST_EMIT;
                    end else if (!i_token_is_nonterminal
                                 && {1'b0, i_token_symbol} >= r_tcount) begin
                        n_pend = mk_err(ERR_TERMINAL, r_cur, r_count); pend_ld = 1'b1;
                        n_fsm  = ST_EMIT;
                    end else begin
                        n_fsm = ST_ACT;
                    end
                end
            end
            ST_ACT: n_fsm = ST_DECIDE;
            ST_DECIDE: begin
                pend_ld = 1'b1;
                n_fsm   = ST_EMIT;
                if (!r_act_ok || t_act'(dec_act) == ACT_ERROR) begin
                    n_pend = mk_err(ERR_NO_ACTION, r_cur, r_count);
                end else if (t_act'(dec_act) == ACT_SHIFT) begin
                    if (32'(r_count) >= STACK_DEPTH) begin
                        n_pend = mk_err(ERR_OVERFLOW, r_cur, r_count);
                    end else begin
                        n_pend.kind  = KIND_SHIFT;
                        n_pend.rule  = '0;
                        n_pend.sym   = '0;
                        n_pend.state = dec_tgt;
                        n_pend.err   = ERR_NONE;
                        n_pend.level = r_count + 1'b1;
                        n_pend.last  = 1'b1;
                        stk_we = 1'b1;
                    end
                end else if (t_act'(dec_act) == ACT_ACCEPT) begin
                    if (r_count != LEN_W'(1)) begin
                        n_pend = mk_err(ERR_UNDERFLOW, r_cur, r_count);
                    end else begin
                        n_pend.kind  = KIND_ACCEPT;
                        n_pend.rule  = '0;
                        n_pend.sym   = '0;
                        n_pend.state = r_cur;
                        n_pend.err   = ERR_NONE;
                        n_pend.level = r_count;
                        n_pend.last  = 1'b1;
                    end
                end else begin
                    if (32'(r_nred) >= MAX_REDUCTIONS) begin
                        n_pend = mk_err(ERR_TOO_MANY, r_cur, r_count);
                    end else if (32'(dec_tgt) >= NUM_RULES) begin
                        n_pend = mk_err(ERR_NO_ACTION, r_cur, r_count);
                    end else begin
                        pend_ld = 1'b0;
                        n_fsm   = ST_RULE;
                    end
                end
            end
            ST_RULE: begin
                if (rq_len > r_count) begin
                    n_pend = mk_err(ERR_UNDERFLOW, r_cur, r_count); pend_ld = 1'b1;
                    n_fsm  = ST_EMIT;
                end else begin
                    n_fsm = ST_POP;
                end
            end
            ST_POP: n_fsm = ST_GOTO;
            ST_GOTO: n_fsm = ST_EMIT;
            ST_EMIT: begin
                if (r_emit_hold) begin
                    // Goto read has landed: finish the reduce.
                    if (!r_act_ok || t_act'(dec_act) == ACT_ERROR) begin
                        push_data = mk_err(ERR_NO_GOTO, r_cur, r_count);
                    end else if (32'(r_base) >= STACK_DEPTH) begin
                        push_data = mk_err(ERR_OVERFLOW, r_cur, r_count);
                    end else begin
                        push_data.kind  = KIND_REDUCE;
                        push_data.rule  = r_rule;
                        push_data.sym   = r_lhs;
                        push_data.state = dec_tgt;
                        push_data.err   = ERR_NONE;
                        push_data.level = r_base + 1'b1;
                        push_data.last  = 1'b0;
                    end
                end
                if (!out_full) begin
                    out_push = 1'b1;
                    if (r_emit_hold && push_data.kind == KIND_REDUCE) begin
                        stk_we    = 1'b1;
                        stk_waddr = SP_W'(r_base);
                        stk_wdata = r_prev;
                        n_fsm     = ST_ACT;
                    end else begin
                        n_fsm = ST_IDLE;
                    end
                end
            end
            default: n_fsm = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pend_ld) begin
            r_pend <= n_pend;
        end
        if (r_fsm == ST_IDLE && accept_in) begin
            r_col <= tok_col;
        end
        if (r_fsm == ST_DECIDE) begin
            r_rule <= dec_tgt;
        end
        if (r_fsm == ST_RULE) begin
            r_lhs  <= rq_lhs;
            r_base <= r_count - rq_len;
        end
        if (r_fsm == ST_POP) begin
            r_prev <= (r_base == r_count) ? r_cur : stk_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nred <= '0;
        end else if (r_fsm == ST_IDLE && accept_in) begin
            r_nred <= '0;
        end else if (r_fsm == ST_EMIT && out_push && r_emit_hold) begin
            r_nred <= r_nred + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_hold <= 1'b0;
        end else if (r_fsm == ST_GOTO) begin
            r_emit_hold <= 1'b1;
        end else if (pend_ld) begin
            r_emit_hold <= 1'b0;
        end
    end

    lrsr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (push_data),
        .o_full  (out_full),
        .o_valid (out_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_valid           = out_valid;
    assign o_result_kind     = out_data.kind;
    assign o_reduced_rule    = out_data.rule;
    assign o_produced_symbol = out_data.sym;
    assign o_new_state       = out_data.state;
    assign o_error_code      = out_data.err;
    assign o_stack_level     = out_data.level;
    assign o_last            = out_data.last;

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_fsm)) else $error("controller state not one-hot");
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= STACK_DEPTH) else $error("stack level beyond depth");
    a_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != RUN_GOING |-> r_fsm == ST_IDLE || r_fsm == ST_EMIT)
        else $error("engine busy after end of parse");
    a_reduce_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_nred) <= MAX_REDUCTIONS) else $error("reduction count overrun");
endmodule
